// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse pattern sequencer package
// Table sizes, field widths, status codes and the item/result structs shared
// by the sequencer modules.
// ----------------------------------------------------------------------------
package pps_pkg;

	// table geometry
	localparam int SLOTS     = 8;
	localparam int STAGES    = 4;
	localparam int PINS      = 8;
	localparam int IN_DELAYS = 4;

	// field widths fixed by the item format
	localparam int ID_W   = 4;
	localparam int PIN_W  = 3;
	localparam int CNT_W  = 16;
	localparam int LVL_W  = 8;
	localparam int STAT_W = 2;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ADD  = 1'b1;

	// add status codes
	localparam logic [STAT_W-1:0] ST_TICK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_ADDED = 2'd1;
	localparam logic [STAT_W-1:0] ST_DUP   = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef logic [STAGES-1:0][CNT_W-1:0] stage_cnt_t;

	typedef struct packed {
		logic                            cmd;
		logic [ID_W-1:0]                 task_id;
		logic [PIN_W-1:0]                pin_select;
		logic [IN_DELAYS-1:0][CNT_W-1:0] on_delay;
		logic [IN_DELAYS-1:0][CNT_W-1:0] off_delay;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0]  pin_levels;
		logic [STAT_W-1:0] add_status;
		logic              busy;
	} result_t;

endpackage

// ===== hdl/pps_slot_table.sv =====
// ----------------------------------------------------------------------------
// Pulse pattern sequencer slot table
// Holds the task slots and pin levels; applies one add or tick per go pulse
// and presents the result of that item combinationally.
// ----------------------------------------------------------------------------
module pps_slot_table
	import pps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  item_t   item,
	output result_t res
);

	logic              active_q [SLOTS];
	logic [ID_W-1:0]   id_q     [SLOTS];
	logic [PIN_W-1:0]  pin_q    [SLOTS];
	logic              high_q   [SLOTS];
	stage_cnt_t        on_q     [SLOTS];
	stage_cnt_t        off_q    [SLOTS];
	logic [PINS-1:0]   pins_q;

	logic              is_add;
	logic              dup;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic              do_load;
	logic              hit;
	logic [SLOT_W-1:0] sel;
	logic              sel_high;
	stage_cnt_t        cur_cnt;
	logic              stg_found;
	logic [STG_W-1:0]  stg_idx;
	logic [CNT_W-1:0]  cnt_dec;
	logic              do_tick;
	stage_cnt_t        ld_on;
	stage_cnt_t        ld_off;
	logic [SLOTS-1:0]  active_nxt;
	logic [PINS-1:0]   pins_nxt;
	logic [LVL_W-1:0]  lvl;
	logic [STAT_W-1:0] status;

	// id match over every slot (free slots carry id zero), lowest free slot and lowest active slot
	always_comb begin
		is_add     = (item.cmd == CMD_ADD);
		dup        = 1'b0;
		free_found = 1'b0;
		free_idx   = '0;
		hit        = 1'b0;
		sel        = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (id_q[s] == item.task_id)
				dup = 1'b1;
		end
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (!active_q[s]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(s);
			end
			if (active_q[s]) begin
				hit = 1'b1;
				sel = SLOT_W'(s);
			end
		end
		do_load = is_add && !dup && free_found;
		do_tick = !is_add && hit;
	end

	// first nonzero count of the served slot's current phase
	always_comb begin
		sel_high  = high_q[sel];
		cur_cnt   = sel_high ? on_q[sel] : off_q[sel];
		stg_found = 1'b0;
		stg_idx   = '0;
		for (int k = STAGES - 1; k >= 0; k--) begin
			if (cur_cnt[k] != '0) begin
				stg_found = 1'b1;
				stg_idx   = STG_W'(k);
			end
		end
		cnt_dec = cur_cnt[stg_idx] - CNT_W'(1);
	end

	// delay values loaded on add; stages beyond the item's fields load zero
	always_comb begin
		for (int k = 0; k < STAGES; k++) begin
			if (k < IN_DELAYS) begin
				ld_on[k]  = item.on_delay[k];
				ld_off[k] = item.off_delay[k];
			end else begin
				ld_on[k]  = '0;
				ld_off[k] = '0;
			end
		end
	end

	// next activity and pin levels
	always_comb begin
		for (int s = 0; s < SLOTS; s++)
			active_nxt[s] = active_q[s];
		pins_nxt = pins_q;
		if (do_load)
			active_nxt[free_idx] = 1'b1;
		if (do_tick) begin
			if (!stg_found)
				active_nxt[sel] = 1'b0;
			if (int'(pin_q[sel]) < PINS)
				pins_nxt[pin_q[sel]] = stg_found && sel_high && (cnt_dec != '0);
		end
	end

	// result fields
	always_comb begin
		for (int i = 0; i < LVL_W; i++)
			lvl[i] = (i < PINS) ? pins_nxt[i] : 1'b0;
		if (!is_add)
			status = ST_TICK;
		else if (dup)
			status = ST_DUP;
		else if (free_found)
			status = ST_ADDED;
		else
			status = ST_FULL;
		res.pin_levels = lvl;
		res.add_status = status;
		res.busy       = |active_nxt;
	end

	// slot control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				active_q[s] <= 1'b0;
				id_q[s]     <= '0;
				high_q[s]   <= 1'b1;
			end
			pins_q <= '0;
		end else if (go) begin
			for (int s = 0; s < SLOTS; s++)
				active_q[s] <= active_nxt[s];
			pins_q <= pins_nxt;
			if (do_load) begin
				id_q[free_idx]   <= item.task_id;
				high_q[free_idx] <= 1'b1;
			end
			if (do_tick) begin
				if (!stg_found) begin
					id_q[sel]   <= '0;
					high_q[sel] <= !sel_high;
				end else if (cnt_dec == '0) begin
					high_q[sel] <= !sel_high;
				end
			end
		end
	end

	// slot payload: pin and counts, only read while the slot is active
	always_ff @(posedge clk) begin
		if (go) begin
			if (do_load) begin
				pin_q[free_idx] <= item.pin_select;
				on_q[free_idx]  <= ld_on;
				off_q[free_idx] <= ld_off;
			end
			if (do_tick && stg_found) begin
				if (sel_high)
					on_q[sel][stg_idx] <= cnt_dec;
				else
					off_q[sel][stg_idx] <= cnt_dec;
			end
		end
	end

endmodule

// ===== hdl/gpio_pulse_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// GPIO pulse pattern sequencer
// Button-press emulator: a table of pulse tasks drives output pins through
// alternating high and low phases, one tick at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: cmd 0 is one
//   elapsed tick, cmd 1 adds a task with its id, pin and four high and four
//   low tick counts. Output channel (out_valid/out_ready) returns exactly one
//   result per item: pin levels after the item, add status and busy flag.
//   An accepted item is captured in the input register, processed by the
//   slot table and its result is registered in the result register once
//   that register is empty or being taken; out_valid rises with that result.
//   Throughput: one item per cycle unless the output stalls; the slot table
//   does the whole add or tick in one pass between input and result register.
//   Stall: while out_ready is low with a result pending, the item in the
//   input register waits and in_ready drops once that register is occupied.
//   Reset: arst_n clears all slots to free (id 0), all pins low and both
//   pipeline registers empty; the block takes items straight after reset.
// ----------------------------------------------------------------------------
module gpio_pulse_pattern_sequencer
	import pps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [ID_W-1:0]   task_id,
	input  logic [PIN_W-1:0]  pin_select,
	input  logic [CNT_W-1:0]  on_delay_0,
	input  logic [CNT_W-1:0]  on_delay_1,
	input  logic [CNT_W-1:0]  on_delay_2,
	input  logic [CNT_W-1:0]  on_delay_3,
	input  logic [CNT_W-1:0]  off_delay_0,
	input  logic [CNT_W-1:0]  off_delay_1,
	input  logic [CNT_W-1:0]  off_delay_2,
	input  logic [CNT_W-1:0]  off_delay_3,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LVL_W-1:0]  pin_levels,
	output logic [STAT_W-1:0] add_status,
	output logic              busy_res
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    adv;
	logic    go;
	logic    in_take;

	// handshake: result register frees when empty or being taken
	assign adv      = !out_valid_q || out_ready;
	assign go       = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;
	assign in_take  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd        <= cmd;
			item_s1.task_id    <= task_id;
			item_s1.pin_select <= pin_select;
			item_s1.on_delay   <= {on_delay_3, on_delay_2, on_delay_1, on_delay_0};
			item_s1.off_delay  <= {off_delay_3, off_delay_2, off_delay_1, off_delay_0};
		end
	end

	// slot table and sequencing logic
	pps_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			res_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign pin_levels = res_q.pin_levels;
	assign add_status = res_q.add_status;
	assign busy_res   = res_q.busy;

endmodule

// ===== hdl/pps_checker.sv =====
// ----------------------------------------------------------------------------
// Pulse pattern sequencer port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module pps_checker
	import pps_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [LVL_W-1:0]  pin_levels,
	input logic [STAT_W-1:0] add_status,
	input logic              busy_res
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pin_levels)
			&& $stable(add_status) && $stable(busy_res))
		else $error("result changed while stalled");

	// input only backs up behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output stall");

	// with no task left every pin has been released low
	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> pin_levels == '0)
		else $error("pin high with no active task");

	// a successful add or a full table implies an active slot
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (add_status == ST_ADDED || add_status == ST_FULL) |-> busy_res)
		else $error("add result without busy");

endmodule

bind gpio_pulse_pattern_sequencer pps_checker u_pps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.pin_levels (pin_levels),
	.add_status (add_status),
	.busy_res   (busy_res)
);

// ===== sim/gpio_pulse_pattern_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// GPIO pulse pattern sequencer testbench
// Drives tick and add items through the input handshake; checks each result
// against a local model of the slot table or a directed row's typed result.
// A short directed table covers reset, duplicate ids, id 0, table full and
// phase flips, then random task streams with bursty input and stalling output.
// ----------------------------------------------------------------------------
module gpio_pulse_pattern_sequencer_test;
	import pps_pkg::*;

	localparam int MAXC         = 2**CNT_W - 1;
	localparam int RANDOM_ITEMS = 2000;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PLAN_ROWS    = 24;

	// one directed row; typed expectations only where obvious
	typedef struct {
		logic              c;
		int                id;
		int                pin;
		int                on_d[IN_DELAYS];
		int                off_d[IN_DELAYS];
		bit                typed;
		int                lv;
		logic [STAT_W-1:0] st;
		bit                bz;
	} plan_row_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic              cmd         = CMD_TICK;
	logic [ID_W-1:0]   task_id     = '0;
	logic [PIN_W-1:0]  pin_select  = '0;
	logic [CNT_W-1:0]  on_delay_0  = '0;
	logic [CNT_W-1:0]  on_delay_1  = '0;
	logic [CNT_W-1:0]  on_delay_2  = '0;
	logic [CNT_W-1:0]  on_delay_3  = '0;
	logic [CNT_W-1:0]  off_delay_0 = '0;
	logic [CNT_W-1:0]  off_delay_1 = '0;
	logic [CNT_W-1:0]  off_delay_2 = '0;
	logic [CNT_W-1:0]  off_delay_3 = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [LVL_W-1:0]  pin_levels;
	logic [STAT_W-1:0] add_status;
	logic              busy_res;

	// local copy of the slot table
	logic              slot_busy [SLOTS];
	logic [ID_W-1:0]   slot_id   [SLOTS];
	logic [PIN_W-1:0]  slot_pin  [SLOTS];
	logic              slot_high [SLOTS];
	stage_cnt_t        slot_on   [SLOTS];
	stage_cnt_t        slot_off  [SLOTS];
	logic [LVL_W-1:0]  pin_lvl;

	result_t awaited_results[$];
	int      mismatches  = 0;
	int      cycles      = 0;
	int      burst_left  = 0;

	plan_row_t plan [PLAN_ROWS] = '{
		// tick straight after reset, add fields ignored
		'{CMD_TICK, 15, 7, '{MAXC, MAXC, MAXC, MAXC}, '{MAXC, MAXC, MAXC, MAXC},
			1'b1, 0, ST_TICK, 1'b0},
		// id 0 matches a free slot
		'{CMD_ADD, 0, 0, '{1, 1, 1, 1}, '{1, 1, 1, 1}, 1'b1, 0, ST_DUP, 1'b0},
		'{CMD_ADD, 15, 7, '{1, 0, 0, 0}, '{0, 0, 0, 2}, 1'b1, 0, ST_ADDED, 1'b1},
		'{CMD_ADD, 15, 0, '{MAXC, MAXC, MAXC, MAXC}, '{MAXC, MAXC, MAXC, MAXC},
			1'b1, 0, ST_DUP, 1'b1},
		// high count ends, low phase skips zeros, then empty high phase frees
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		// task with no counts at all
		'{CMD_ADD, 1, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		// fill the table, ids 2 and 3 share pin 3
		'{CMD_ADD, 1, 0, '{2, 0, 0, 0}, '{1, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_ADD, 2, 3, '{0, 1, 0, 0}, '{0, 0, 1, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_ADD, 3, 3, '{1, 0, 0, 1}, '{1, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_ADD, 4, 1, '{1, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_ADD, 5, 2, '{2, 0, 0, 0}, '{2, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_ADD, 6, 4, '{1, 0, 0, 0}, '{1, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_ADD, 7, 5, '{1, 0, 0, 0}, '{1, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_ADD, 8, 6, '{1, 0, 0, 0}, '{1, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		// no free slot left: id 0 and a fresh id are both rejected as full
		'{CMD_ADD, 0, 0, '{1, 0, 0, 0}, '{1, 0, 0, 0}, 1'b1, 0, ST_FULL, 1'b1},
		'{CMD_ADD, 9, 7, '{MAXC, MAXC, MAXC, MAXC}, '{MAXC, MAXC, MAXC, MAXC},
			1'b1, 0, ST_FULL, 1'b1},
		// duplicate wins over full
		'{CMD_ADD, 5, 0, '{1, 0, 0, 0}, '{1, 0, 0, 0}, 1'b1, 0, ST_DUP, 1'b1},
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0},
		'{CMD_TICK, 0, 0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0, 0, ST_TICK, 1'b0}
	};

	gpio_pulse_pattern_sequencer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.task_id     (task_id),
		.pin_select  (pin_select),
		.on_delay_0  (on_delay_0),
		.on_delay_1  (on_delay_1),
		.on_delay_2  (on_delay_2),
		.on_delay_3  (on_delay_3),
		.off_delay_0 (off_delay_0),
		.off_delay_1 (off_delay_1),
		.off_delay_2 (off_delay_2),
		.off_delay_3 (off_delay_3),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pin_levels  (pin_levels),
		.add_status  (add_status),
		.busy_res    (busy_res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// table state after reset
	initial begin
		for (int s = 0; s < SLOTS; s++) begin
			slot_busy[s] = 1'b0;
			slot_id[s]   = '0;
			slot_pin[s]  = '0;
			slot_high[s] = 1'b1;
			slot_on[s]   = '0;
			slot_off[s]  = '0;
		end
		pin_lvl = '0;
	end

	// apply one item to the local table and return the result it gives
	function automatic result_t advance_pulse_table(input item_t it);
		result_t    r;
		int         hit;
		int         k;
		int         p;
		bit         high;
		stage_cnt_t cnt;

		r            = '0;
		r.add_status = ST_TICK;
		if (it.cmd == CMD_ADD) begin
			r.add_status = ST_FULL;
			for (int s = 0; s < SLOTS; s++)
				if (slot_id[s] == it.task_id)
					r.add_status = ST_DUP;
			for (int s = 0; s < SLOTS; s++) begin
				if (r.add_status == ST_FULL && !slot_busy[s]) begin
					slot_busy[s] = 1'b1;
					slot_id[s]   = it.task_id;
					slot_pin[s]  = it.pin_select;
					slot_high[s] = 1'b1;
					for (int j = 0; j < STAGES; j++) begin
						slot_on[s][j]  = (j < IN_DELAYS) ? it.on_delay[j] : '0;
						slot_off[s][j] = (j < IN_DELAYS) ? it.off_delay[j] : '0;
					end
					r.add_status = ST_ADDED;
				end
			end
		end else begin
			// only the lowest active slot moves on a tick
			hit = -1;
			for (int s = 0; s < SLOTS; s++)
				if (slot_busy[s] && hit < 0)
					hit = s;
			if (hit >= 0) begin
				high = slot_high[hit];
				p    = slot_pin[hit];
				cnt  = high ? slot_on[hit] : slot_off[hit];
				k    = 0;
				while (k < STAGES && cnt[k] == 0)
					k++;
				if (k < STAGES) begin
					if (p < PINS && p < LVL_W)
						pin_lvl[p] = high;
					cnt[k] = cnt[k] - CNT_W'(1);
					if (cnt[k] == 0) begin
						slot_high[hit] = !high;
						if (high && p < PINS && p < LVL_W)
							pin_lvl[p] = 1'b0;
					end
					if (high)
						slot_on[hit] = cnt;
					else
						slot_off[hit] = cnt;
				end else begin
					// phase exhausted: task done, slot freed
					slot_busy[hit] = 1'b0;
					slot_id[hit]   = '0;
					slot_high[hit] = !high;
					if (p < PINS && p < LVL_W)
						pin_lvl[p] = 1'b0;
				end
			end
		end
		for (int s = 0; s < SLOTS; s++)
			if (slot_busy[s])
				r.busy = 1'b1;
		r.pin_levels = pin_lvl;
		return r;
	endfunction

	// present one item, wait for acceptance, log its result, then maybe idle
	task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
		result_t predicted;
		int      gap;

		in_valid    <= 1'b1;
		cmd         <= it.cmd;
		task_id     <= it.task_id;
		pin_select  <= it.pin_select;
		on_delay_0  <= it.on_delay[0];
		on_delay_1  <= it.on_delay[1];
		on_delay_2  <= it.on_delay[2];
		on_delay_3  <= it.on_delay[3];
		off_delay_0 <= it.off_delay[0];
		off_delay_1 <= it.off_delay[1];
		off_delay_2 <= it.off_delay[2];
		off_delay_3 <= it.off_delay[3];
		do
			@(posedge clk);
		while (!in_ready);
		predicted = advance_pulse_table(it);
		awaited_results.push_back(typed ? typed_res : predicted);

		// bursts with random gaps, some bursts back to back
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// output side: check each result, stall on a pattern of changing modes
	initial begin
		result_t exp_res;
		int      stall_mode;
		int      mode_left;
		int      phase;

		stall_mode = 0;
		mode_left  = 0;
		phase      = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: pin_levels %0h add_status %0d busy_res %0b",
						pin_levels, add_status, busy_res);
					mismatches++;
				end else begin
					exp_res = awaited_results.pop_front();
					if (pin_levels !== exp_res.pin_levels) begin
						$error("pin_levels: expected %0h, got %0h",
							exp_res.pin_levels, pin_levels);
						mismatches++;
					end
					if (add_status !== exp_res.add_status) begin
						$error("add_status: expected %0d, got %0d",
							exp_res.add_status, add_status);
						mismatches++;
					end
					if (busy_res !== exp_res.busy) begin
						$error("busy_res: expected %0b, got %0b", exp_res.busy, busy_res);
						mismatches++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 200);
			end
			mode_left--;
			phase++;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (phase % 4 == 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// stimulus
	initial begin
		item_t   it;
		result_t typed_res;
		int      r;
		int      pick;
		int      n_active;
		bit      clash;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int i = 0; i < PLAN_ROWS; i++) begin
			it            = '0;
			it.cmd        = plan[i].c;
			it.task_id    = ID_W'(plan[i].id);
			it.pin_select = PIN_W'(plan[i].pin);
			for (int k = 0; k < IN_DELAYS; k++) begin
				it.on_delay[k]  = CNT_W'(plan[i].on_d[k]);
				it.off_delay[k] = CNT_W'(plan[i].off_d[k]);
			end
			typed_res            = '0;
			typed_res.pin_levels = LVL_W'(plan[i].lv);
			typed_res.add_status = plan[i].st;
			typed_res.busy       = plan[i].bz;
			send_item(it, plan[i].typed, typed_res);
		end

		// random task streams
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			it            = '0;
			it.task_id    = ID_W'($urandom);
			it.pin_select = PIN_W'($urandom);
			for (int k = 0; k < IN_DELAYS; k++) begin
				it.on_delay[k]  = CNT_W'($urandom);
				it.off_delay[k] = CNT_W'($urandom);
			end
			n_active = 0;
			for (int s = 0; s < SLOTS; s++)
				if (slot_busy[s])
					n_active++;
			r = $urandom_range(0, 99);
			if (r < ((n_active < SLOTS - 2) ? 15 : 4)) begin
				// well-formed add: fresh id, short counts with skipped stages
				it.cmd = CMD_ADD;
				clash  = 1'b1;
				while (clash) begin
					pick  = $urandom_range(1, 15);
					clash = 1'b0;
					for (int s = 0; s < SLOTS; s++)
						if (slot_id[s] == pick)
							clash = 1'b1;
				end
				it.task_id = ID_W'(pick);
				for (int k = 0; k < IN_DELAYS; k++) begin
					pick           = $urandom_range(0, 9);
					it.on_delay[k] = CNT_W'((pick < 5) ? 0 :
						(pick < 9) ? $urandom_range(1, 4) : $urandom_range(5, 12));
					pick            = $urandom_range(0, 9);
					it.off_delay[k] = CNT_W'((pick < 5) ? 0 :
						(pick < 9) ? $urandom_range(1, 4) : $urandom_range(5, 12));
				end
			end else if (r < 22) begin
				// add that is always dropped: an id in use, or 0 of a free slot
				it.cmd     = CMD_ADD;
				it.task_id = slot_id[$urandom_range(0, SLOTS - 1)];
			end else begin
				it.cmd = CMD_TICK;
			end
			send_item(it, 1'b0, '0);
		end

		// drain the table, then load full-range counts and run a few ticks
		n_active = 1;
		while (n_active > 0) begin
			it     = '0;
			it.cmd = CMD_TICK;
			send_item(it, 1'b0, '0);
			n_active = 0;
			for (int s = 0; s < SLOTS; s++)
				if (slot_busy[s])
					n_active++;
		end
		it            = '0;
		it.cmd        = CMD_ADD;
		it.task_id    = ID_W'(15);
		it.pin_select = PIN_W'(7);
		for (int k = 0; k < IN_DELAYS; k++) begin
			it.on_delay[k]  = CNT_W'(MAXC);
			it.off_delay[k] = CNT_W'(MAXC);
		end
		send_item(it, 1'b0, '0);
		for (int n = 0; n < 20; n++) begin
			it     = '0;
			it.cmd = CMD_TICK;
			send_item(it, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
